// ----- hw/rtl/vtsp_pkg.sv -----
// Shared types and constants for the VLAN tag stack parser.
// No dependencies; imported by vtsp_core and vlan_tag_stack_parser.
`default_nettype none
package vtsp_pkg;

    localparam int unsigned MAX_TAGS    = 8;
    localparam int unsigned TAG_CNT_W   = 4;
    localparam int unsigned TAG_IDX_W   = 3;

    localparam logic [15:0] DEFAULT_VLAN_TYPE = 16'h8100;

    // Byte position inside a four-byte group
    localparam logic [1:0] PHASE_TAG_HI  = 2'd0;
    localparam logic [1:0] PHASE_TAG_LO  = 2'd1;
    localparam logic [1:0] PHASE_TYPE_HI = 2'd2;
    localparam logic [1:0] PHASE_TYPE_LO = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_FINAL = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [15:0]          tag_value;
        logic [15:0]          next_ethertype;
        logic [TAG_IDX_W-1:0] tag_index;
        logic [1:0]           status;
    } out_word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vtsp_core.sv -----
// Per-byte tag stack parse step: frame state registers and result logic.
// Depends on vtsp_pkg.
`default_nettype none
module vtsp_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_en,
    input  wire vtsp_pkg::in_word_t item,
    input  wire logic [15:0]        vlan_type,
    output logic                    res_valid,
    output vtsp_pkg::out_word_t     res
);
    import vtsp_pkg::*;

    logic [1:0]           phase_reg, phase_next;
    logic [15:0]          tag_hold_reg, tag_hold_next;
    logic [7:0]           type_high_reg, type_high_next;
    logic [TAG_CNT_W-1:0] tag_count_reg, tag_count_next;
    logic                 done_reg, done_next;
    logic [15:0]          ethertype;

    assign ethertype = {type_high_reg, item.data_byte};

    always_comb
    begin
        phase_next     = phase_reg;
        tag_hold_next  = tag_hold_reg;
        type_high_next = type_high_reg;
        tag_count_next = tag_count_reg;
        done_next      = done_reg;
        res_valid      = 1'b0;
        res.tag_value      = tag_hold_reg;
        res.next_ethertype = ethertype;
        res.tag_index      = tag_count_reg[TAG_IDX_W-1:0];
        res.status         = ST_MORE;

        if (!done_reg)
        begin
            unique case (phase_reg)
                PHASE_TAG_HI:  tag_hold_next  = {item.data_byte, 8'h00};
                PHASE_TAG_LO:  tag_hold_next  = {tag_hold_reg[15:8], item.data_byte};
                PHASE_TYPE_HI: type_high_next = item.data_byte;
                default:       ;
            endcase

            if (phase_reg == PHASE_TYPE_LO)
            begin
                res_valid  = 1'b1;
                phase_next = PHASE_TAG_HI;
                priority if (tag_count_reg >= TAG_CNT_W'(MAX_TAGS))
                begin
                    res.status = ST_OVER;
                    done_next  = 1'b1;
                end
                else if (ethertype != vlan_type)
                begin
                    res.status = ST_FINAL;
                    done_next  = 1'b1;
                end
                else if (item.last_byte)
                begin
                    res.status = ST_TRUNC;
                end
                else
                begin
                    res.status     = ST_MORE;
                    tag_count_next = tag_count_reg + 1'b1;
                end
            end
            else
            begin
                // Data ran out inside a group
                if (item.last_byte)
                begin
                    res_valid          = 1'b1;
                    res.tag_value      = '0;
                    res.next_ethertype = '0;
                    res.status         = ST_TRUNC;
                end
                phase_next = phase_reg + 1'b1;
            end
        end

        // Drop all frame state at the end of the frame
        if (item.last_byte)
        begin
            phase_next     = PHASE_TAG_HI;
            tag_hold_next  = '0;
            type_high_next = '0;
            tag_count_next = '0;
            done_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_TAG_HI;
            tag_hold_reg  <= '0;
            type_high_reg <= '0;
            tag_count_reg <= '0;
            done_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            tag_hold_reg  <= tag_hold_next;
            type_high_reg <= type_high_next;
            tag_count_reg <= tag_count_next;
            done_reg      <= done_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tag_count_reg <= TAG_CNT_W'(MAX_TAGS))
        else $error("tag count beyond the stack limit");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && item.last_byte) |=>
            (phase_reg == PHASE_TAG_HI && tag_count_reg == '0 && !done_reg))
        else $error("frame state not cleared after last byte");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !res_valid)
        else $error("result produced after the stack ended");

    a_more_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res_valid && res.status == ST_MORE) |=>
            (tag_count_reg == $past(tag_count_reg) + 1'b1))
        else $error("continuing tag did not advance the count");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/vlan_tag_stack_parser.sv -----
// Top level of the VLAN tag stack parser: input word register, parse core,
// result register and the ethertype configuration register. Uses vtsp_pkg, vtsp_core.
`default_nettype none
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one frame byte per
//   word, starting at the first tag control word, with last_byte marking the
//   final available byte of the frame.
//   Output channel (out_valid / out_stall / out_data) carries one word per
//   completed tag group or early end of data: tag value, following
//   ethertype, tag position and status (more, final, truncated, too many).
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
//   ethertype that marks a further stacked tag; write it only while idle.
// Timing:
//   One input word per cycle sustained while no result is stalled. A byte lands
//   in the input register, passes through the parse step and is written to the
//   result register when the step fires; a stalled result holds that step back.
//   The combinational parse step over the registered byte sets the rate.
// Reset:
//   Clears frame state, both valid flags, and loads ethertype 0x8100.
// Back pressure:
//   While out_stall holds a waiting result, the registered byte is held and
//   in_stall rises once the input register is full; nothing is lost.
module vlan_tag_stack_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire vtsp_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output vtsp_pkg::out_word_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data
);
    import vtsp_pkg::*;

    in_word_t    in_reg;
    logic        in_valid_reg;
    out_word_t   out_reg;
    logic        out_valid_reg;
    logic [15:0] vlan_type_reg;

    logic        fire;
    logic        take;
    logic        res_valid;
    out_word_t   res;

    // Advance the registered byte when the result slot is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign take     = in_valid && !in_stall;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    vtsp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (fire),
        .item      (in_reg),
        .vlan_type (vlan_type_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vlan_type_reg <= DEFAULT_VLAN_TYPE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                vlan_type_reg <= cfg_data;

            // Hold the input word until the parse step takes it
            if (take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            // Load a new result, or drop the delivered one
            if (fire)
                out_valid_reg <= res_valid;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= in_data;
        if (fire && res_valid)
            out_reg <= res;
    end

endmodule
`default_nettype wire
